>>> sv/wavhdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wavhdr_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam int unsigned FMT_FIELD_BYTES = 16;

   localparam logic [2:0] ST_PARSING   = 3'd0;
   localparam logic [2:0] ST_COMPLETE  = 3'd1;
   localparam logic [2:0] ST_NOT_RIFF  = 3'd2;
   localparam logic [2:0] ST_NOT_WAVE  = 3'd3;
   localparam logic [2:0] ST_NOT_PCM   = 3'd4;

   typedef enum logic [15:0] {
      PH_RIFF        = 16'h0001,
      PH_RIFF_SIZE   = 16'h0002,
      PH_WAVE        = 16'h0004,
      PH_FMT_ID      = 16'h0008,
      PH_FMT_SKSIZE  = 16'h0010,
      PH_FMT_SKBODY  = 16'h0020,
      PH_FMT_SIZE    = 16'h0040,
      PH_FMT_BODY    = 16'h0080,
      PH_DATA_ID     = 16'h0100,
      PH_DATA_SKSIZE = 16'h0200,
      PH_DATA_SKBODY = 16'h0400,
      PH_DATA_SIZE   = 16'h0800,
      PH_DONE        = 16'h1000,
      PH_ERR_RIFF    = 16'h2000,
      PH_ERR_WAVE    = 16'h4000,
      PH_ERR_PCM     = 16'h8000
   } phase_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] data_size;
      logic [15:0] bits_per_sample;
      logic [15:0] block_align;
      logic [31:0] byte_rate;
      logic [31:0] sample_rate;
      logic [15:0] channel_count;
      logic [2:0]  status;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/wav_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | tdata                             | tuser
// req     | in        | data_byte                         | file_start
// rsp     | out       | status .. data_size (152 bits)    | -
//
// one byte per cycle while req_tready is high; each accepted byte gives one result
// the whole parse step for a byte sits between the state registers
// reset clears all parse state and both output stages
// a two-entry output (result register plus skid) keeps req_tready high while
// one result waits; req_tready drops only when both entries are full

module wav_header_parser (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire  [7:0]                req_tdata,  // data_byte[7:0]
   input  wire  [0:0]                req_tuser,  // file_start[0]
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   output wavhdr_pkg::rsp_type       rsp_tdata   // status[2:0], channel_count[18:3],
                                                 // sample_rate[50:19], byte_rate[82:51],
                                                 // block_align[98:83],
                                                 // bits_per_sample[114:99],
                                                 // data_size[146:115], zero[151:147]
);
   import wavhdr_pkg::*;

   phase_type   phase_ff, phase_in, phase_c;
   logic [1:0]  pos_ff, pos_in, pos_c;
   logic [31:0] wb_ff, wb_in, wb_c, wb_shift;
   logic [31:0] skip_ff, skip_in, skip_c, skip_dec;
   logic [4:0]  fmt_ff, fmt_in, fmt_c;
   logic [15:0] ch_ff, ch_in, ch_c;
   logic [31:0] sr_ff, sr_in, sr_c;
   logic [31:0] br_ff, br_in, br_c;
   logic [15:0] ba_ff, ba_in, ba_c;
   logic [15:0] bits_ff, bits_in, bits_c;
   logic [31:0] ds_ff, ds_in, ds_c;
   logic        word_done;
   logic        pcm_err;
   logic [7:0]  b;
   logic        accept;
   rsp_type     result;

   logic        out_valid_ff;
   rsp_type     out_ff;
   logic        skid_valid_ff;
   rsp_type     skid_ff;
   logic        out_load;

   assign b      = req_tdata;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      if (req_tuser[0]) begin
         phase_c = PH_RIFF;
         pos_c   = '0;
         wb_c    = '0;
         skip_c  = '0;
         fmt_c   = '0;
         ch_c    = '0;
         sr_c    = '0;
         br_c    = '0;
         ba_c    = '0;
         bits_c  = '0;
         ds_c    = '0;
      end else begin
         phase_c = phase_ff;
         pos_c   = pos_ff;
         wb_c    = wb_ff;
         skip_c  = skip_ff;
         fmt_c   = fmt_ff;
         ch_c    = ch_ff;
         sr_c    = sr_ff;
         br_c    = br_ff;
         ba_c    = ba_ff;
         bits_c  = bits_ff;
         ds_c    = ds_ff;
      end

      wb_shift  = {b, wb_c[31:8]};
      word_done = (pos_c == 2'd3);
      skip_dec  = skip_c - 32'd1;
      pcm_err   = 1'b0;

      phase_in = phase_c;
      pos_in   = pos_c;
      wb_in    = wb_c;
      skip_in  = skip_c;
      fmt_in   = fmt_c;
      ch_in    = ch_c;
      sr_in    = sr_c;
      br_in    = br_c;
      ba_in    = ba_c;
      bits_in  = bits_c;
      ds_in    = ds_c;

      case (phase_c)
         PH_RIFF: begin
            pos_in = pos_c + 2'd1;
            wb_in  = wb_shift;
            if (word_done) begin
               phase_in = (wb_shift == TAG_RIFF) ? PH_RIFF_SIZE : PH_ERR_RIFF;
            end
         end
         PH_RIFF_SIZE: begin
            pos_in = pos_c + 2'd1;
            wb_in  = wb_shift;
            if (word_done) begin
               phase_in = PH_WAVE;
            end
         end
         PH_WAVE: begin
            pos_in = pos_c + 2'd1;
            wb_in  = wb_shift;
            if (word_done) begin
               phase_in = (wb_shift == TAG_WAVE) ? PH_FMT_ID : PH_ERR_WAVE;
            end
         end
         PH_FMT_ID: begin
            pos_in = pos_c + 2'd1;
            wb_in  = wb_shift;
            if (word_done) begin
               phase_in = (wb_shift == TAG_FMT) ? PH_FMT_SIZE : PH_FMT_SKSIZE;
            end
         end
         PH_DATA_ID: begin
            pos_in = pos_c + 2'd1;
            wb_in  = wb_shift;
            if (word_done) begin
               phase_in = (wb_shift == TAG_DATA) ? PH_DATA_SIZE : PH_DATA_SKSIZE;
            end
         end
         PH_FMT_SKSIZE: begin
            pos_in = pos_c + 2'd1;
            wb_in  = wb_shift;
            if (word_done) begin
               skip_in  = wb_shift;
               phase_in = (wb_shift == 32'd0) ? PH_FMT_ID : PH_FMT_SKBODY;
            end
         end
         PH_DATA_SKSIZE: begin
            pos_in = pos_c + 2'd1;
            wb_in  = wb_shift;
            if (word_done) begin
               skip_in  = wb_shift;
               phase_in = (wb_shift == 32'd0) ? PH_DATA_ID : PH_DATA_SKBODY;
            end
         end
         PH_FMT_SKBODY: begin
            skip_in = skip_dec;
            if (skip_dec == 32'd0) begin
               phase_in = PH_FMT_ID;
            end
         end
         PH_DATA_SKBODY: begin
            skip_in = skip_dec;
            if (skip_dec == 32'd0) begin
               phase_in = PH_DATA_ID;
            end
         end
         PH_FMT_SIZE: begin
            pos_in = pos_c + 2'd1;
            wb_in  = wb_shift;
            if (word_done) begin
               skip_in  = wb_shift;
               fmt_in   = '0;
               phase_in = (wb_shift == 32'd0) ? PH_DATA_ID : PH_FMT_BODY;
            end
         end
         PH_FMT_BODY: begin
            if (fmt_c < 5'(FMT_FIELD_BYTES)) begin
               if (fmt_c == 5'd0) begin
                  wb_in = {24'd0, b};
               end else if (fmt_c == 5'd1) begin
                  wb_in = wb_c | {16'd0, b, 8'd0};
                  if ((wb_c | {16'd0, b, 8'd0}) != 32'd1) begin
                     pcm_err = 1'b1;
                  end
               end else if (fmt_c < 5'd4) begin
                  ch_in[{fmt_c[0], 3'b000} +: 8] = b;
               end else if (fmt_c < 5'd8) begin
                  sr_in[{fmt_c[1:0], 3'b000} +: 8] = b;
               end else if (fmt_c < 5'd12) begin
                  br_in[{fmt_c[1:0], 3'b000} +: 8] = b;
               end else if (fmt_c < 5'd14) begin
                  ba_in[{fmt_c[0], 3'b000} +: 8] = b;
               end else begin
                  bits_in[{fmt_c[0], 3'b000} +: 8] = b;
               end
               fmt_in = fmt_c + 5'd1;
            end
            if (pcm_err) begin
               phase_in = PH_ERR_PCM;
            end else begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  if (fmt_in == 5'd1) begin
                     phase_in = PH_ERR_PCM;
                  end else begin
                     wb_in    = '0;
                     phase_in = PH_DATA_ID;
                  end
               end
            end
         end
         PH_DATA_SIZE: begin
            pos_in = pos_c + 2'd1;
            wb_in  = wb_shift;
            if (word_done) begin
               ds_in    = wb_shift;
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase

      result                 = '0;
      result.channel_count   = ch_in;
      result.sample_rate     = sr_in;
      result.byte_rate       = br_in;
      result.block_align     = ba_in;
      result.bits_per_sample = bits_in;
      result.data_size       = ds_in;
      case (phase_in)
         PH_DONE:     result.status = ST_COMPLETE;
         PH_ERR_RIFF: result.status = ST_NOT_RIFF;
         PH_ERR_WAVE: result.status = ST_NOT_WAVE;
         PH_ERR_PCM:  result.status = ST_NOT_PCM;
         default:     result.status = ST_PARSING;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         pos_ff   <= '0;
         wb_ff    <= '0;
         skip_ff  <= '0;
         fmt_ff   <= '0;
         ch_ff    <= '0;
         sr_ff    <= '0;
         br_ff    <= '0;
         ba_ff    <= '0;
         bits_ff  <= '0;
         ds_ff    <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         wb_ff    <= wb_in;
         skip_ff  <= skip_in;
         fmt_ff   <= fmt_in;
         ch_ff    <= ch_in;
         sr_ff    <= sr_in;
         br_ff    <= br_in;
         ba_ff    <= ba_in;
         bits_ff  <= bits_in;
         ds_ff    <= ds_in;
      end
   end

   // result register with skid entry
   assign out_load   = !out_valid_ff || rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_load) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (!out_load && accept) begin
         skid_ff <= result;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a transaction while result register is empty");

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser[0]) |=> (phase_ff == PH_RIFF))
      else $error("file start did not restart the tag check");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tuser[0] &&
       (phase_ff == PH_ERR_RIFF || phase_ff == PH_ERR_WAVE || phase_ff == PH_ERR_PCM ||
        phase_ff == PH_DONE)) |=> $stable(phase_ff))
      else $error("final parse state left without file start");

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && !out_valid_ff) |=> out_valid_ff)
      else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
